### src/inverse_cylindrical_point_transform_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the inverse cylindrical point transform
// Concurrent checks on the top level, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef INVERSE_CYLINDRICAL_POINT_TRANSFORM_DEFINES_SVH
`define INVERSE_CYLINDRICAL_POINT_TRANSFORM_DEFINES_SVH
`ifndef SYNTH
// Implication checked on every clock edge outside reset.
`define ICPT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icpt implication check failed");
// Next-cycle implication that is also checked while reset is applied.
`define ICPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("icpt next-cycle check failed");
`else
`define ICPT_ASSERT_IMPL(lbl, ante, cons)
`define ICPT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/icpt_pkg.sv
// ---------------------------------------------------------------------------
// icpt_pkg
// Shared widths, constants and payload types of the point transform.
// ---------------------------------------------------------------------------
package icpt_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word WORD_MAX = t_word'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam t_word WORD_MIN = t_word'({1'b1, {(WORD_BITS-1){1'b0}}});
    localparam t_word FX_ONE   = t_word'(64'd1 << FRAC_BITS);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_EN_X_POLAR = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EN_Y_POLAR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_SCALE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Z_SCALE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVERALL_SCALE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DE_GAIN = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DE_OFFSET = 3'd6;

    // Radians to 32-bit phase: round(2^32 / (2*pi)).
    localparam logic [29:0] PHASE_K = 30'd683565276;
    // Odd polynomial for a quarter-wave sine, Q30 coefficients.
    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [29:0] SIN_B = 30'd688904866;
    localparam logic [26:0] SIN_C = 27'd76016977;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    typedef struct packed {
        t_word x_in;
        t_word y_in;
        t_word z_in;
        t_word w_in;
        t_word de_in;
    } t_in;

    typedef struct packed {
        t_word x_out;
        t_word y_out;
        t_word z_out;
        t_word w_out;
        t_word de_out;
    } t_out;

endpackage

### src/inverse_cylindrical_point_transform.sv
// ---------------------------------------------------------------------------
// inverse_cylindrical_point_transform
// Pipelined inverse cylindrical fold of a 4-D point and its distance estimate.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ----------------------------------
//  input     i_start && !o_busy        i_in (x, y, z, w, de)
//  result    o_done, one-cycle strobe  o_result (x, y, z, w, de)
//  config    i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A new point is taken in every clock cycle; o_busy is never raised because
// every stage of the chain hands its contents on in every cycle.
// The result of a transfer appears on o_result with o_done after it has
// passed the longest dependent path, which runs through
// the input register, a phase cell, a
// five-stage sine cell, a multiply, a second multiply, another phase and
// sine, and two more multiplies plus the output register.
// Reset is synchronous; it clears the valid chain and o_done, and returns the configuration to its defaults.
// The receiver cannot stall, so nothing in the chain ever holds.
`include "inverse_cylindrical_point_transform_defines.svh"

module inverse_cylindrical_point_transform
    import icpt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  t_in                     i_in,
    output logic                    o_done,
    output t_out                    o_result,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  t_word                   i_cfg_data
);

    localparam int LAST_ITEM = 15;
    localparam int LAST_VLD  = 16;

    // Configuration registers.
    logic  r_en_x;
    logic  r_en_y;
    t_word r_angle_scale;
    t_word r_z_scale;
    t_word r_overall_scale;
    t_word r_de_gain;
    t_word r_de_offset;

    // Payload delay chain and its valid bits.
    t_in   r_item [0:LAST_ITEM];
    logic  r_vld  [0:LAST_VLD];
    t_word r_px   [8:14];
    logic  r_done;
    t_out  r_result;

    logic [31:0] ph_y;
    logic [31:0] ph_pa;
    logic [31:0] ph_ya;
    t_word sin_y, cos_y;
    t_word m_px, m_py;
    t_word px, py;
    t_word m_pa, m_ya;
    t_word cos_pa, sin_ya;
    t_word abs_s;
    t_word m_x1, m_y1, m_z1, m_de1;
    t_word m_x2, m_y2, m_z2, m_w2, m_de2;
    logic signed [WORD_BITS:0] de_sum;
    t_word de_sat;

    assign o_busy = 1'b0;

    // Register writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_x          <= 1'b0;
            r_en_y          <= 1'b0;
            r_angle_scale   <= FX_ONE;
            r_z_scale       <= FX_ONE;
            r_overall_scale <= FX_ONE;
            r_de_gain       <= FX_ONE;
            r_de_offset     <= FX_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EN_X_POLAR:    r_en_x          <= i_cfg_data[0];
                REG_EN_Y_POLAR:    r_en_y          <= i_cfg_data[0];
                REG_ANGLE_SCALE:   r_angle_scale   <= i_cfg_data;
                REG_Z_SCALE:       r_z_scale       <= i_cfg_data;
                REG_OVERALL_SCALE: r_overall_scale <= i_cfg_data;
                REG_DE_GAIN:       r_de_gain       <= i_cfg_data;
                REG_DE_OFFSET:     r_de_offset     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The input point rides along the chain so that every stage can reach
    // the coordinates it needs at the matching cycle.
    always_ff @(posedge i_clk) begin
        r_item[0] <= i_in;
        for (int k = 1; k <= LAST_ITEM; k++) begin
            r_item[k] <= r_item[k-1];
        end
        r_px[8] <= px;
        for (int k = 9; k <= 14; k++) begin
            r_px[k] <= r_px[k-1];
        end
        r_result <= '{x_out: m_x2, y_out: m_y2, z_out: m_z2, w_out: m_w2,
                      de_out: de_sat};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST_VLD; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_done <= 1'b0;
        end else begin
            r_vld[0] <= i_start;
            for (int k = 1; k <= LAST_VLD; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_done <= r_vld[LAST_VLD];
        end
    end

    // Polar pre-step: sine and cosine of y, aligned with stage 6.
    icpt_phase u_ph_y (.i_clk(i_clk), .i_angle(r_item[0].y_in), .o_phase(ph_y));
    icpt_sin u_sin_y (.i_clk(i_clk), .i_phase(ph_y), .o_sin(sin_y));
    icpt_sin u_cos_y (.i_clk(i_clk), .i_phase(ph_y + QUARTER_TURN), .o_sin(cos_y));

    icpt_fxmul u_mul_px (.i_clk(i_clk), .i_a(r_item[6].x_in), .i_b(cos_y), .o_p(m_px));
    icpt_fxmul u_mul_py (.i_clk(i_clk), .i_a(r_item[6].x_in), .i_b(sin_y), .o_p(m_py));

    assign px = r_en_x ? m_px : r_item[7].x_in;
    assign py = r_en_y ? m_py : r_item[7].y_in;

    // Scaled angles and their sine and cosine, aligned with stage 14.
    icpt_fxmul u_mul_pa (.i_clk(i_clk), .i_a(py), .i_b(r_angle_scale), .o_p(m_pa));
    icpt_fxmul u_mul_ya (.i_clk(i_clk), .i_a(r_item[7].y_in), .i_b(r_angle_scale),
                         .o_p(m_ya));
    icpt_phase u_ph_pa (.i_clk(i_clk), .i_angle(m_pa), .o_phase(ph_pa));
    icpt_phase u_ph_ya (.i_clk(i_clk), .i_angle(m_ya), .o_phase(ph_ya));
    icpt_sin u_cos_pa (.i_clk(i_clk), .i_phase(ph_pa + QUARTER_TURN), .o_sin(cos_pa));
    icpt_sin u_sin_ya (.i_clk(i_clk), .i_phase(ph_ya), .o_sin(sin_ya));

    // The most negative scale has no positive twin and saturates.
    assign abs_s = (r_overall_scale == WORD_MIN) ? WORD_MAX
                 : (r_overall_scale[WORD_BITS-1] ? -r_overall_scale : r_overall_scale);

    // First product of the x, y, z and distance outputs, aligned with stage 15.
    icpt_fxmul u_mul_x1 (.i_clk(i_clk), .i_a(r_item[14].x_in), .i_b(cos_pa), .o_p(m_x1));
    icpt_fxmul u_mul_y1 (.i_clk(i_clk), .i_a(r_px[14]), .i_b(sin_ya), .o_p(m_y1));
    icpt_fxmul u_mul_z1 (.i_clk(i_clk), .i_a(r_item[14].z_in), .i_b(r_z_scale),
                         .o_p(m_z1));
    icpt_fxmul u_mul_d1 (.i_clk(i_clk), .i_a(r_item[14].de_in), .i_b(abs_s),
                         .o_p(m_de1));

    // Overall scale and distance gain, aligned with stage 16.
    icpt_fxmul u_mul_x2 (.i_clk(i_clk), .i_a(m_x1), .i_b(r_overall_scale), .o_p(m_x2));
    icpt_fxmul u_mul_y2 (.i_clk(i_clk), .i_a(m_y1), .i_b(r_overall_scale), .o_p(m_y2));
    icpt_fxmul u_mul_z2 (.i_clk(i_clk), .i_a(m_z1), .i_b(r_overall_scale), .o_p(m_z2));
    icpt_fxmul u_mul_w2 (.i_clk(i_clk), .i_a(r_item[LAST_ITEM].w_in),
                         .i_b(r_overall_scale), .o_p(m_w2));
    icpt_fxmul u_mul_d2 (.i_clk(i_clk), .i_a(m_de1), .i_b(r_de_gain), .o_p(m_de2));

    // Saturating offset add for the distance estimate.
    always_comb begin
        de_sum = (WORD_BITS+1)'(m_de2) + (WORD_BITS+1)'(r_de_offset);
        if (de_sum > (WORD_BITS+1)'(WORD_MAX)) begin
            de_sat = WORD_MAX;
        end else if (de_sum < (WORD_BITS+1)'(WORD_MIN)) begin
            de_sat = WORD_MIN;
        end else begin
            de_sat = t_word'(de_sum);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Every accepted point produces exactly one strobe.
    `ICPT_ASSERT_IMPL(a_start_to_done, i_start, ##18 o_done)
    `ICPT_ASSERT_IMPL(a_done_from_start, o_done, $past(i_start, 18))
    `ICPT_ASSERT_NEXT(a_reset_clears, !i_rst_n, !o_done && !r_en_x && !r_en_y)

endmodule

### src/icpt_fxmul.sv
// ---------------------------------------------------------------------------
// icpt_fxmul
// Registered fixed-point multiply with round-half-away and saturation.
// ---------------------------------------------------------------------------
module icpt_fxmul
    import icpt_pkg::*;
(
    input  logic  i_clk,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_p
);

    localparam int PW = 2 * WORD_BITS;
    localparam int QW = PW + 1 - FRAC_BITS;

    logic                 neg;
    logic [WORD_BITS-1:0] ma;
    logic [WORD_BITS-1:0] mb;
    logic [PW-1:0]        prod;
    logic [PW:0]          prod_r;
    logic [QW-1:0]        q;
    logic [WORD_BITS:0]   lim;
    logic [WORD_BITS:0]   mag;
    t_word                n_p;
    t_word                r_p;

    always_comb begin
        neg    = i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
        ma     = i_a[WORD_BITS-1] ? WORD_BITS'(-i_a) : WORD_BITS'(i_a);
        mb     = i_b[WORD_BITS-1] ? WORD_BITS'(-i_b) : WORD_BITS'(i_b);
        prod   = PW'(ma) * PW'(mb);
        prod_r = (PW+1)'(prod) + (PW+1)'(64'd1 << (FRAC_BITS - 1));
        q      = prod_r[PW:FRAC_BITS];
        // The negative side reaches one step further than the positive side.
        lim    = (WORD_BITS+1)'(WORD_MAX) + (WORD_BITS+1)'(neg);
        mag    = (q > QW'(lim)) ? lim : q[WORD_BITS:0];
        n_p    = neg ? t_word'(-mag) : t_word'(mag);
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

### src/icpt_phase.sv
// ---------------------------------------------------------------------------
// icpt_phase
// Registered conversion of a fixed-point radian angle to a 32-bit phase.
// ---------------------------------------------------------------------------
module icpt_phase
    import icpt_pkg::*;
(
    input  logic        i_clk,
    input  t_word       i_angle,
    output logic [31:0] o_phase
);

    localparam int PW = WORD_BITS + 30;

    logic [WORD_BITS-1:0] mag;
    logic [PW-1:0]        prod;
    logic [31:0]          p;
    logic [31:0]          n_phase;
    logic [31:0]          r_phase;

    always_comb begin
        mag     = i_angle[WORD_BITS-1] ? WORD_BITS'(-i_angle) : WORD_BITS'(i_angle);
        prod    = PW'(mag) * PW'(PHASE_K);
        p       = prod[FRAC_BITS+31:FRAC_BITS];
        n_phase = i_angle[WORD_BITS-1] ? (32'd0 - p) : p;
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
    end

    assign o_phase = r_phase;

endmodule

### src/icpt_sin.sv
// ---------------------------------------------------------------------------
// icpt_sin
// Five-stage sine of a 32-bit phase; all but the last stage do one multiply.
// ---------------------------------------------------------------------------
module icpt_sin
    import icpt_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_phase,
    output t_word       o_sin
);

    logic [30:0] x0;
    logic [61:0] xx;
    logic [57:0] ct;
    logic [29:0] bt;
    logic [60:0] bp;
    logic [30:0] at;
    logic [61:0] ap;
    logic [32:0] sr;
    t_word       n_sin;

    logic [1:0]  r1_q, r2_q, r3_q, r4_q;
    logic [30:0] r1_x, r2_x, r3_x;
    logic [30:0] r1_x2, r2_x2;
    logic [27:0] r2_t1;
    logic [30:0] r3_t2;
    logic [31:0] r4_s;
    t_word       r5_sin;

    always_comb begin
        // Odd quadrants run the quarter wave backwards.
        x0 = i_phase[30] ? (31'(QUARTER_TURN) - {1'b0, i_phase[29:0]})
                         : {1'b0, i_phase[29:0]};
        xx = 62'(x0) * 62'(x0);
        ct = 58'(SIN_C) * 58'(r1_x2);
        bt = SIN_B - 30'(r2_t1);
        bp = 61'(bt) * 61'(r2_x2);
        at = SIN_A - r3_t2;
        ap = 62'(at) * 62'(r3_x);
        sr = (33'(r4_s) + 33'(64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        n_sin = r4_q[1] ? -t_word'(sr) : t_word'(sr);
    end

    always_ff @(posedge i_clk) begin
        r1_q  <= i_phase[31:30];
        r1_x  <= x0;
        r1_x2 <= xx[60:30];
        r2_q  <= r1_q;
        r2_x  <= r1_x;
        r2_x2 <= r1_x2;
        r2_t1 <= ct[57:30];
        r3_q  <= r2_q;
        r3_x  <= r2_x;
        r3_t2 <= bp[60:30];
        r4_q  <= r3_q;
        r4_s  <= ap[61:30];
        r5_sin <= n_sin;
    end

    assign o_sin = r5_sin;

endmodule

### tb/sv/inverse_cylindrical_point_transform_test.sv
// ---------------------------------------------------------------------------
// inverse_cylindrical_point_transform_test
// Self-checking bench for the point transform. A behavioral predictor with
// its own copy of the configuration computes each expected point, and every
// o_done strobe is compared field by field with the oldest expectation.
// ---------------------------------------------------------------------------
module inverse_cylindrical_point_transform_test;
    import icpt_pkg::*;

    localparam int LATENCY = 18;
    localparam int DRAIN_CYCLES = LATENCY + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam longint PH_K = 64'd683565276;
    localparam longint SA = 64'd1686629713;
    localparam longint SB = 64'd688904866;
    localparam longint SC = 64'd76016977;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_start;
    logic                    o_busy;
    t_in                     i_in;
    logic                    o_done;
    t_out                    o_result;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    t_word                   i_cfg_data;

    inverse_cylindrical_point_transform dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_in(i_in), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // The predictor keeps its own copy of the configuration.
    logic  polar_x, polar_y;
    t_word ang_scale, zs, ovs, gain, offs;

    t_out  expected_points[$];
    int    fail_count = 0;
    int    point_count = 0;
    int    idle_pct = 0;
    int    idle_cycles = 0;

    // Signed Q16.16 product, magnitude rounded half away from zero, saturated.
    function automatic t_word fx_mul(t_word a, t_word b);
        logic [63:0] ma, mb;
        logic [127:0] p;
        logic neg;
        logic [63:0] lim;
        neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        ma = a[WORD_BITS-1] ? 64'(-longint'(a)) : 64'(a);
        mb = b[WORD_BITS-1] ? 64'(-longint'(b)) : 64'(b);
        p = (128'(ma) * 128'(mb) + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if (p > 128'(lim)) p = 128'(lim);
        return neg ? t_word'(-longint'(p[63:0])) : t_word'(p[31:0]);
    endfunction

    function automatic logic [31:0] rad_to_phase(t_word r);
        logic [63:0] m;
        logic [127:0] p;
        logic [31:0] ph;
        m = r[WORD_BITS-1] ? 64'(-longint'(r)) : 64'(r);
        p = (128'(m) * 128'(PH_K)) >> FRAC_BITS;
        ph = p[31:0];
        return r[WORD_BITS-1] ? -ph : ph;
    endfunction

    function automatic t_word phase_sine(logic [31:0] ph);
        logic [1:0] quad;
        logic [63:0] f, f2, t, s;
        quad = ph[31:30];
        f = {34'd0, ph[29:0]};
        if (quad[0]) f = (64'd1 << 30) - f;
        f2 = (f * f) >> 30;
        t = (SC * f2) >> 30;
        t = ((SB - t) * f2) >> 30;
        s = ((SA - t) * f) >> 30;
        s = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return quad[1] ? t_word'(-longint'(s)) : t_word'(s);
    endfunction

    function automatic t_out predict_point(t_in p);
        t_out  r;
        t_word px, py, abs_s;
        longint sum;
        px = polar_x ? fx_mul(p.x_in, phase_sine(rad_to_phase(p.y_in) + QUARTER_TURN))
                     : p.x_in;
        py = polar_y ? fx_mul(p.x_in, phase_sine(rad_to_phase(p.y_in))) : p.y_in;
        r.x_out = fx_mul(fx_mul(p.x_in,
            phase_sine(rad_to_phase(fx_mul(py, ang_scale)) + QUARTER_TURN)), ovs);
        r.y_out = fx_mul(fx_mul(px, phase_sine(rad_to_phase(fx_mul(p.y_in, ang_scale)))),
                         ovs);
        r.z_out = fx_mul(fx_mul(p.z_in, zs), ovs);
        r.w_out = fx_mul(p.w_in, ovs);
        abs_s = (ovs == WORD_MIN) ? WORD_MAX : (ovs < 0 ? -ovs : ovs);
        sum = longint'(fx_mul(fx_mul(p.de_in, abs_s), gain)) + longint'(offs);
        if (sum > longint'(WORD_MAX)) sum = longint'(WORD_MAX);
        if (sum < longint'(WORD_MIN)) sum = longint'(WORD_MIN);
        r.de_out = t_word'(sum);
        return r;
    endfunction

    // Result checker: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_done) begin
            if (expected_points.size() == 0) begin
                $error("result with no expected point pending");
                fail_count++;
            end else begin
                e = expected_points.pop_front();
                if (o_result.x_out !== e.x_out) begin
                    $error("x_out expected %0d got %0d", e.x_out, o_result.x_out);
                    fail_count++;
                end
                if (o_result.y_out !== e.y_out) begin
                    $error("y_out expected %0d got %0d", e.y_out, o_result.y_out);
                    fail_count++;
                end
                if (o_result.z_out !== e.z_out) begin
                    $error("z_out expected %0d got %0d", e.z_out, o_result.z_out);
                    fail_count++;
                end
                if (o_result.w_out !== e.w_out) begin
                    $error("w_out expected %0d got %0d", e.w_out, o_result.w_out);
                    fail_count++;
                end
                if (o_result.de_out !== e.de_out) begin
                    $error("de_out expected %0d got %0d", e.de_out, o_result.de_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transfer happens in either direction.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** inverse_cylindrical_point_transform: FAILED **");
            $finish;
        end
    end

    // Sends one point, with a random idle gap at the current idling rate.
    // Start stays high across back-to-back transfers.
    task automatic send_point(t_in p);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= p;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expected_points.push_back(predict_point(p));
        point_count++;
    endtask

    // Waits for all expected points and the pipeline to empty.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Drives a write on the register port, drops the write enable and updates the predictor's copy.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, t_word val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_EN_X_POLAR:    polar_x   = val[0];
            REG_EN_Y_POLAR:    polar_y   = val[0];
            REG_ANGLE_SCALE:   ang_scale = val;
            REG_Z_SCALE:       zs        = val;
            REG_OVERALL_SCALE: ovs       = val;
            REG_DE_GAIN:       gain      = val;
            REG_DE_OFFSET:     offs      = val;
            default: ;
        endcase
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(5, 0))
            0: return t_word'($urandom);
            1: return t_word'($urandom_range(65536 * 8, 0)) - t_word'(65536 * 4);
            2: return $urandom_range(1, 0) ? WORD_MAX : WORD_MIN;
            3: return t_word'($urandom_range(65536 * 200, 0)) - t_word'(65536 * 100);
            default: return t_word'($signed($urandom) >>> $urandom_range(20, 0));
        endcase
    endfunction

    function automatic t_in rand_point();
        t_in p;
        p.x_in = rand_word();
        p.y_in = rand_word();
        p.z_in = rand_word();
        p.w_in = rand_word();
        p.de_in = rand_word();
        return p;
    endfunction

    // Extremes of every field, zero, unit values, and quarter-turn angles.
    task automatic test_directed();
        t_word vals[8];
        t_in p;
        vals = '{WORD_MIN, WORD_MAX, 0, FX_ONE, -FX_ONE, t_word'(102944),
                 t_word'(-205887), t_word'(1)};
        idle_pct = 0;
        for (int i = 0; i < 8; i++) begin
            p.x_in = vals[i]; p.y_in = vals[(i + 3) % 8]; p.z_in = vals[(i + 1) % 8];
            p.w_in = vals[(i + 5) % 8]; p.de_in = vals[(i + 2) % 8];
            send_point(p);
        end
        p = '{FX_ONE, t_word'(102944), WORD_MAX, WORD_MIN, WORD_MAX};
        send_point(p);
        p = '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN};
        send_point(p);
        p = '{-1, -1, -1, -1, -1};
        send_point(p);
        drain();
    endtask

    // Random configuration, including the extremes of every register.
    task automatic set_config(int sel);
        write_reg(REG_EN_X_POLAR, t_word'(sel & 1));
        write_reg(REG_EN_Y_POLAR, t_word'((sel >> 1) & 1));
        case (sel % 4)
            0: begin
                write_reg(REG_ANGLE_SCALE, WORD_MAX);
                write_reg(REG_Z_SCALE, WORD_MIN);
                write_reg(REG_OVERALL_SCALE, WORD_MIN);
                write_reg(REG_DE_GAIN, WORD_MAX);
                write_reg(REG_DE_OFFSET, WORD_MIN);
            end
            1: begin
                write_reg(REG_ANGLE_SCALE, WORD_MIN);
                write_reg(REG_Z_SCALE, WORD_MAX);
                write_reg(REG_OVERALL_SCALE, WORD_MAX);
                write_reg(REG_DE_GAIN, WORD_MIN);
                write_reg(REG_DE_OFFSET, WORD_MAX);
            end
            default: begin
                write_reg(REG_ANGLE_SCALE, rand_word());
                write_reg(REG_Z_SCALE, rand_word());
                write_reg(REG_OVERALL_SCALE, rand_word());
                write_reg(REG_DE_GAIN, rand_word());
                write_reg(REG_DE_OFFSET, rand_word());
            end
        endcase
    endtask

    // Random points in several idling phases under changing configurations.
    task automatic test_random();
        int rates[4];
        rates = '{0, 53, 0, 23};
        for (int cfg = 0; cfg < 12; cfg++) begin
            set_config(cfg == 11 ? 2 : cfg);
            idle_pct = rates[cfg % 4];
            for (int n = 0; n < 135; n++) send_point(rand_point());
            drain();
        end
        // Restore unit scales and run once more with polar folds off.
        write_reg(REG_EN_X_POLAR, 0);
        write_reg(REG_EN_Y_POLAR, 0);
        write_reg(REG_ANGLE_SCALE, FX_ONE);
        write_reg(REG_Z_SCALE, FX_ONE);
        write_reg(REG_OVERALL_SCALE, FX_ONE);
        write_reg(REG_DE_GAIN, FX_ONE);
        write_reg(REG_DE_OFFSET, 0);
        idle_pct = 53;
        for (int n = 0; n < 20; n++) send_point(rand_point());
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0; i_start = 1'b0; i_in = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        polar_x = 1'b0; polar_y = 1'b0;
        ang_scale = FX_ONE; zs = FX_ONE; ovs = FX_ONE; gain = FX_ONE; offs = FX_ONE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        $display("Checked %0d points across 14 register settings, with and without",
                 point_count);
        $display("polar folds, saturating extremes and random sender gaps.");
        if (fail_count == 0 && expected_points.size() == 0) begin
            $display("** inverse_cylindrical_point_transform: PASSED **");
        end else begin
            $display("** inverse_cylindrical_point_transform: FAILED **");
        end
        $finish;
    end
endmodule
